/* rtl/core/mpb_pkg.sv */
// Shared types and constants for the Morse pattern blinker.
package mpb_pkg;

  // Fixed field widths
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned LenW     = 6;
  localparam int unsigned PosW     = 5;
  localparam int unsigned TickW    = 16;
  localparam int unsigned HalfW    = 32;

  // Register reset values
  localparam logic [LenW-1:0]  LenReset     = LenW'(1);
  localparam logic [TickW-1:0] DotReset     = TickW'(250);
  localparam logic [TickW-1:0] DashReset    = TickW'(750);
  localparam logic [TickW-1:0] GapReset     = TickW'(1000);
  localparam logic [TickW-1:0] SpacingReset = TickW'(100);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MESSAGE_LENGTH    = 3'd0,
    REG_SYMBOLS_LOW_HALF  = 3'd1,
    REG_SYMBOLS_HIGH_HALF = 3'd2,
    REG_DOT_TICKS         = 3'd3,
    REG_DASH_TICKS        = 3'd4,
    REG_GAP_TICKS         = 3'd5,
    REG_SPACING_TICKS     = 3'd6
  } cfg_reg_e;

  // Two-bit symbol codes
  typedef enum logic [1:0] {
    SYM_OTHER = 2'd0,
    SYM_DOT   = 2'd1,
    SYM_DASH  = 2'd2,
    SYM_GAP   = 2'd3
  } sym_e;

  // Playback phase
  typedef enum logic {
    PH_SYMBOL  = 1'b0,
    PH_SPACING = 1'b1
  } phase_e;

endpackage

/* rtl/core/mpb_if.sv */
// Handshake channel interfaces: tick/restart items, results and register writes.
interface mpb_item_if import mpb_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface mpb_result_if import mpb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            led_lit;
  logic [PosW-1:0] symbol_index;
  logic            in_spacing;
  modport source (output valid, output led_lit, output symbol_index, output in_spacing,
                  input ready);
  modport sink   (input valid, input led_lit, input symbol_index, input in_spacing,
                  output ready);
endinterface

interface mpb_cfg_if import mpb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* rtl/core/morse_pattern_blinker.sv */
// Morse pattern blinker: plays a looping two-bit symbol pattern on one LED.
// Result: the result of an item is registered and presented in the cycle after its beat is taken.
// Throughput: one item per cycle unless the result stalls; the playback state doubles as the result
// register, so a new beat is taken whenever the result slot is empty or drains.
// Reset: asynchronous, clears phase, position, countdown and LED and loads the
// register defaults; configuration writes are always accepted.
module morse_pattern_blinker
  import mpb_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = 32,
  parameter int unsigned TIMER_BITS  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mpb_item_if.sink     item_i,
  mpb_result_if.source result_o,
  mpb_cfg_if.sink      cfg_i
);

  localparam logic [TIMER_BITS-1:0] TimerMax = '1;
  localparam logic [LenW-1:0]       MaxLen   = LenW'(MAX_SYMBOLS);

  // Configuration registers
  logic [LenW-1:0]   msg_len_q;
  logic [HalfW-1:0]  sym_lo_q, sym_hi_q;
  logic [TickW-1:0]  dot_q, dash_q, gap_q, spacing_q;

  // Playback state, also the result register
  phase_e                phase_q, phase_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [TIMER_BITS-1:0] cnt_q, cnt_d;
  logic                  led_q, led_d;
  logic                  res_valid_q;

  logic                  item_beat;
  logic [TIMER_BITS-1:0] cnt_dec;
  logic [LenW-1:0]       len_eff;
  logic [LenW-1:0]       pos_inc;
  logic [31:0][1:0]      sym_arr;
  sym_e                  cur_sym;

  // Saturate a tick count to the timer range
  function automatic logic [TIMER_BITS-1:0] load_time(input logic [TickW-1:0] ticks);
    logic [31:0] t32;
    t32 = 32'(ticks);
    if (t32 > 32'(TimerMax)) begin
      return TimerMax;
    end
    return TIMER_BITS'(t32);
  endfunction

  // Handshakes
  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = !res_valid_q || result_o.ready;
  assign item_beat    = item_i.valid && item_i.ready;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_len_q <= LenReset;
      sym_lo_q  <= '0;
      sym_hi_q  <= '0;
      dot_q     <= DotReset;
      dash_q    <= DashReset;
      gap_q     <= GapReset;
      spacing_q <= SpacingReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_MESSAGE_LENGTH:    msg_len_q <= cfg_i.wdata[LenW-1:0];
        REG_SYMBOLS_LOW_HALF:  sym_lo_q  <= cfg_i.wdata[HalfW-1:0];
        REG_SYMBOLS_HIGH_HALF: sym_hi_q  <= cfg_i.wdata[HalfW-1:0];
        REG_DOT_TICKS:         dot_q     <= cfg_i.wdata[TickW-1:0];
        REG_DASH_TICKS:        dash_q    <= cfg_i.wdata[TickW-1:0];
        REG_GAP_TICKS:         gap_q     <= cfg_i.wdata[TickW-1:0];
        REG_SPACING_TICKS:     spacing_q <= cfg_i.wdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  // Current symbol and wrap point
  assign sym_arr = {sym_hi_q, sym_lo_q};
  assign cur_sym = sym_e'(sym_arr[pos_q]);
  assign len_eff = (msg_len_q > MaxLen) ? MaxLen : msg_len_q;
  assign pos_inc = LenW'(pos_q) + LenW'(1);
  assign cnt_dec = (cnt_q != '0) ? cnt_q - TIMER_BITS'(1) : cnt_q;

  // Next state for one beat
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    led_d   = led_q;
    if (item_i.restart) begin
      phase_d = PH_SYMBOL;
      pos_d   = '0;
      cnt_d   = '0;
      led_d   = 1'b0;
    end else begin
      cnt_d = cnt_dec;
      if (cnt_dec == '0) begin
        unique case (phase_q)
          PH_SYMBOL: begin
            unique case (cur_sym)
              SYM_DASH: begin
                led_d   = 1'b1;
                cnt_d   = load_time(dash_q);
                phase_d = PH_SPACING;
              end
              SYM_DOT: begin
                led_d   = 1'b1;
                cnt_d   = load_time(dot_q);
                phase_d = PH_SPACING;
              end
              SYM_GAP: begin
                led_d   = 1'b0;
                cnt_d   = load_time(gap_q);
                phase_d = PH_SPACING;
              end
              default: begin
                // unknown symbol: stay dark and hold here
                led_d = 1'b0;
                cnt_d = '0;
              end
            endcase
          end
          PH_SPACING: begin
            led_d   = 1'b0;
            cnt_d   = load_time(spacing_q);
            pos_d   = (pos_inc >= len_eff) ? '0 : pos_inc[PosW-1:0];
            phase_d = PH_SYMBOL;
          end
          default: ;
        endcase
      end
    end
  end

  // State register, advanced once per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYMBOL;
      pos_q   <= '0;
      cnt_q   <= '0;
      led_q   <= 1'b0;
    end else if (item_beat) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      led_q   <= led_d;
    end
  end

  // Result slot occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (item_beat) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.led_lit      = led_q;
  assign result_o.symbol_index = pos_q;
  assign result_o.in_spacing   = phase_q;

endmodule

/* rtl/core/mpb_checker.sv */
// Port-level checks for the Morse pattern blinker, bound to the top level.
module mpb_checker
  import mpb_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            in_restart_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic            out_led_i,
  input logic [PosW-1:0] out_index_i,
  input logic            out_spacing_i
);

  // Every taken beat yields a result in the next cycle
  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("no result after accepted beat");

  // A restart beat reports symbol zero, symbol phase, LED dark
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_restart_i |=>
      !out_led_i && (out_index_i == '0) && !out_spacing_i)
    else $error("restart did not clear playback");

  // The LED is only lit while a dot or dash is timing out
  a_dark_in_symbol_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_spacing_i |-> !out_led_i)
    else $error("LED lit in symbol phase");

  // A stalled result holds its payload
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_led_i) && $stable(out_index_i) && $stable(out_spacing_i))
    else $error("stalled result changed");

endmodule

bind morse_pattern_blinker mpb_checker u_mpb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .in_restart_i  (item_i.restart),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_led_i     (result_o.led_lit),
  .out_index_i   (result_o.symbol_index),
  .out_spacing_i (result_o.in_spacing)
);

/* sim/morse_pattern_blinker_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the Morse pattern blinker, with its own playback predictor.
module morse_pattern_blinker_test;
  import mpb_pkg::*;

  localparam int unsigned MaxSymbols = 32;
  localparam int QuietLimit = 4000;
  localparam int PrintLimit = 40;
  localparam logic [CfgIdxW-1:0] RegBeyondList = CfgIdxW'(7);
  localparam logic PulseTick    = 1'b0;
  localparam logic PulseRestart = 1'b1;

  typedef struct packed {
    logic            led;
    logic [PosW-1:0] index;
    phase_e          spacing;
  } playback_t;

  typedef struct {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } reg_write_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mpb_item_if   item_bus ();
  mpb_result_if result_bus ();
  mpb_cfg_if    cfg_bus ();

  morse_pattern_blinker u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  always #5 clk_i = ~clk_i;

  // Predictor copy of the registers and the playback state
  logic [LenW-1:0]  len_reg   = LenReset;
  logic [HalfW-1:0] low_reg   = '0;
  logic [HalfW-1:0] high_reg  = '0;
  logic [TickW-1:0] dot_reg   = DotReset;
  logic [TickW-1:0] dash_reg  = DashReset;
  logic [TickW-1:0] gap_reg   = GapReset;
  logic [TickW-1:0] space_reg = SpacingReset;
  phase_e           play_phase = PH_SYMBOL;
  logic [PosW-1:0]  play_pos   = '0;
  logic [TickW-1:0] play_count = '0;
  logic             play_led   = 1'b0;

  logic       pending_pulses[$];
  reg_write_t pending_writes[$];
  playback_t  expected_playback[$];

  int mismatches   = 0;
  int quiet_cycles = 0;
  int send_gap_pct;
  int sink_stall_pct;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PrintLimit) $display("%0t: mismatch: %s", $time, what);
  endtask

  // One tick or restart through the playback state machine
  function automatic playback_t step_blinker(input logic restart);
    logic [2*HalfW-1:0] pattern;
    int unsigned        next_pos;
    int unsigned        wrap_at;
    playback_t          res;
    pattern = {high_reg, low_reg};
    if (restart) begin
      play_pos   = '0;
      play_phase = PH_SYMBOL;
      play_count = '0;
      play_led   = 1'b0;
    end else begin
      if (play_count != '0) play_count = play_count - 1'b1;
      if (play_count == '0) begin
        if (play_phase == PH_SYMBOL) begin
          case (sym_e'(pattern[2*play_pos +: 2]))
            SYM_DOT: begin
              play_led   = 1'b1;
              play_count = dot_reg;
              play_phase = PH_SPACING;
            end
            SYM_DASH: begin
              play_led   = 1'b1;
              play_count = dash_reg;
              play_phase = PH_SPACING;
            end
            SYM_GAP: begin
              play_led   = 1'b0;
              play_count = gap_reg;
              play_phase = PH_SPACING;
            end
            // 'other' holds dark on the same symbol
            default: begin
              play_led   = 1'b0;
              play_count = '0;
            end
          endcase
        end else begin
          wrap_at  = (len_reg > MaxSymbols) ? MaxSymbols : len_reg;
          next_pos = play_pos + 1;
          if (next_pos >= wrap_at) next_pos = 0;
          play_pos   = PosW'(next_pos);
          play_led   = 1'b0;
          play_count = space_reg;
          play_phase = PH_SYMBOL;
        end
      end
    end
    res.led     = play_led;
    res.index   = play_pos;
    res.spacing = play_phase;
    return res;
  endfunction

  task automatic apply_register(input logic [CfgIdxW-1:0] index,
                                input logic [CfgDataW-1:0] data);
    case (index)
      REG_MESSAGE_LENGTH:    len_reg   = data[LenW-1:0];
      REG_SYMBOLS_LOW_HALF:  low_reg   = data[HalfW-1:0];
      REG_SYMBOLS_HIGH_HALF: high_reg  = data[HalfW-1:0];
      REG_DOT_TICKS:         dot_reg   = data[TickW-1:0];
      REG_DASH_TICKS:        dash_reg  = data[TickW-1:0];
      REG_GAP_TICKS:         gap_reg   = data[TickW-1:0];
      REG_SPACING_TICKS:     space_reg = data[TickW-1:0];
      default: ;
    endcase
  endtask

  // Tick/restart driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_bus.valid   <= 1'b0;
      item_bus.restart <= PulseTick;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        expected_playback.push_back(step_blinker(item_bus.restart));
        pending_pulses.delete(0);
      end
      if (!item_bus.valid || item_bus.ready) begin
        if (pending_pulses.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          item_bus.valid   <= 1'b1;
          item_bus.restart <= pending_pulses[0];
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Register write driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_bus.valid <= 1'b0;
      cfg_bus.index <= '0;
      cfg_bus.wdata <= '0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        apply_register(cfg_bus.index, cfg_bus.wdata);
        pending_writes.delete(0);
      end
      if (!cfg_bus.valid || cfg_bus.ready) begin
        if (pending_writes.size() != 0) begin
          cfg_bus.valid <= 1'b1;
          cfg_bus.index <= pending_writes[0].index;
          cfg_bus.wdata <= pending_writes[0].data;
        end else begin
          cfg_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each beat against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    playback_t want;
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (expected_playback.size() == 0) begin
          report_mismatch($sformatf("unexpected result led=%0b index=%0d spacing=%0b",
                                    result_bus.led_lit, result_bus.symbol_index,
                                    result_bus.in_spacing));
        end else begin
          want = expected_playback.pop_front();
          if (result_bus.led_lit !== want.led)
            report_mismatch($sformatf("led_lit %0b, expected %0b",
                                      result_bus.led_lit, want.led));
          if (result_bus.symbol_index !== want.index)
            report_mismatch($sformatf("symbol_index %0d, expected %0d",
                                      result_bus.symbol_index, want.index));
          if (result_bus.in_spacing !== want.spacing)
            report_mismatch($sformatf("in_spacing %0b, expected %0b",
                                      result_bus.in_spacing, want.spacing));
        end
      end
      result_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("morse_pattern_blinker test failed");
      $finish;
    end
  end

  task automatic set_idling(input int gap_pct, input int stall_pct);
    send_gap_pct   = gap_pct;
    sink_stall_pct = stall_pct;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] data);
    reg_write_t w;
    w.index = index;
    w.data  = data;
    pending_writes.push_back(w);
  endtask

  task automatic queue_pulses(input int count, input int restart_pct);
    for (int n = 0; n < count; n++)
      pending_pulses.push_back(($urandom_range(99) < restart_pct) ? PulseRestart : PulseTick);
  endtask

  // Holds the sender until every write is done and every result is back
  task automatic wait_drained();
    while (pending_pulses.size() != 0 || pending_writes.size() != 0 ||
           expected_playback.size() != 0 || item_bus.valid || cfg_bus.valid)
      @(negedge clk_i);
  endtask

  // Mostly timed symbols, a few 'other' ones that stall the pattern
  function automatic logic [HalfW-1:0] random_pattern(input int other_pct);
    logic [HalfW-1:0] word;
    for (int k = 0; k < HalfW / 2; k++)
      word[2*k +: 2] = ($urandom_range(99) < other_pct) ? SYM_OTHER
                                                          : 2'($urandom_range(SYM_GAP, SYM_DOT));
    return word;
  endfunction

  // Short delays mostly, so that the pattern moves; now and then a long one
  function automatic logic [TickW-1:0] pick_ticks();
    int roll;
    roll = $urandom_range(99);
    if (roll < 2) return '1;
    if (roll < 4) return TickW'($urandom_range(65535));
    return TickW'($urandom_range(4));
  endfunction

  initial begin
    item_bus.valid   = 1'b0;
    item_bus.restart = PulseTick;
    result_bus.ready = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.wdata    = '0;
    rst_ni           = 1'b0;
    set_idling(21, 68);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset pattern is all 'other': LED holds dark at symbol zero
    queue_pulses(2, 0);
    pending_pulses.push_back(PulseRestart);
    queue_pulses(1, 0);
    wait_drained();

    // Dot, dash, gap with zero and short delays, restart part way through
    write_reg(REG_MESSAGE_LENGTH, 3);
    write_reg(REG_SYMBOLS_LOW_HALF, HalfW'({SYM_GAP, SYM_DASH, SYM_DOT}));
    write_reg(REG_DOT_TICKS, 0);
    write_reg(REG_DASH_TICKS, 1);
    write_reg(REG_GAP_TICKS, 2);
    write_reg(REG_SPACING_TICKS, 0);
    wait_drained();
    queue_pulses(10, 0);
    pending_pulses.push_back(PulseRestart);
    queue_pulses(3, 0);
    wait_drained();

    // Zero length wraps every advance to the start; unlisted index is ignored
    write_reg(REG_MESSAGE_LENGTH, 0);
    write_reg(RegBeyondList, '1);
    wait_drained();
    queue_pulses(3, 0);
    wait_drained();

    // Full-scale registers, length above the symbol store
    write_reg(REG_MESSAGE_LENGTH, '1);
    write_reg(REG_SYMBOLS_LOW_HALF, '1);
    write_reg(REG_SYMBOLS_HIGH_HALF, '1);
    write_reg(REG_DOT_TICKS, '1);
    write_reg(REG_DASH_TICKS, '1);
    write_reg(REG_GAP_TICKS, '1);
    write_reg(REG_SPACING_TICKS, '1);
    wait_drained();
    queue_pulses(3, 0);

    // Random rounds: fresh settings each round, state carried across
    for (int round = 0; round < 9; round++) begin
      if (round == 3) set_idling(68, 21);
      else if (round == 6) set_idling(0, 0);
      wait_drained();
      write_reg(REG_MESSAGE_LENGTH, ($urandom_range(9) == 0) ? $urandom_range(63)
                                                             : $urandom_range(32, 1));
      write_reg(REG_SYMBOLS_LOW_HALF, (round == 4) ? $urandom() : random_pattern(8));
      write_reg(REG_SYMBOLS_HIGH_HALF, (round == 4) ? $urandom() : random_pattern(8));
      write_reg(REG_DOT_TICKS, pick_ticks());
      write_reg(REG_DASH_TICKS, pick_ticks());
      write_reg(REG_GAP_TICKS, pick_ticks());
      write_reg(REG_SPACING_TICKS, pick_ticks());
      wait_drained();
      queue_pulses(50, 3);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (expected_playback.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_playback.size()));
    if (mismatches == 0)
      $display("morse_pattern_blinker test passed");
    else
      $display("morse_pattern_blinker test failed");
    $finish;
  end

endmodule
